### rtl/core/tpps_pkg.sv
package tpps_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int VERTEX_WIDTH    = 48;
    localparam int TAG_WIDTH       = 32;
    localparam int VERDICT_WIDTH   = 3;

    typedef enum logic [VERDICT_WIDTH-1:0] {
        VERDICT_STRADDLE    = 3'd0,
        VERDICT_SHARED      = 3'd1,
        VERDICT_B_DEGEN     = 3'd2,
        VERDICT_A_ONE_SIDE  = 3'd3,
        VERDICT_A_DEGEN     = 3'd4,
        VERDICT_B_ONE_SIDE  = 3'd5
    } t_verdict;

    // outcome of one plane test
    typedef struct packed {
        logic degen;
        logic one_side;
    } t_plane_res;

endpackage

### rtl/core/tpps_plane.sv
// Plane of triangle q against the vertices of triangle p, four stages:
// edge/offset differences and cross terms, normal, distance terms, sign sum.
module tpps_plane #(
    parameter int COORD_WIDTH = tpps_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic [3:0]                             i_en,
    input  logic [2:0][2:0][COORD_WIDTH-1:0]       i_p,
    input  logic [2:0][2:0][COORD_WIDTH-1:0]       i_q,
    output tpps_pkg::t_plane_res                   o_res
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int NW = PW + 1;
    localparam int QW = NW + DW;
    localparam int SW = QW + 2;

    // stage 2 regs
    logic signed [PW-1:0] r2_m [3][2];
    logic signed [DW-1:0] r2_d [3][3];
    // stage 3 regs
    logic signed [NW-1:0] r3_n [3];
    logic signed [DW-1:0] r3_d [3][3];
    logic                 r3_degen;
    // stage 4 regs
    logic signed [QW-1:0] r4_t [3][3];
    logic                 r4_degen;
    // stage 5 reg
    tpps_pkg::t_plane_res r5_res;

    logic signed [DW-1:0] n_e1 [3];
    logic signed [DW-1:0] n_e2 [3];
    logic signed [DW-1:0] n_d  [3][3];
    logic signed [PW-1:0] n_m  [3][2];
    logic signed [NW-1:0] n_n  [3];
    logic signed [QW-1:0] n_t  [3][3];
    logic signed [SW-1:0] n_s  [3];
    logic                 n_degen;
    logic [2:0]           n_neg;
    logic [2:0]           n_nz;
    tpps_pkg::t_plane_res n_res;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_e1[c] = $signed({i_q[1][c][COORD_WIDTH-1], i_q[1][c]})
                    - $signed({i_q[0][c][COORD_WIDTH-1], i_q[0][c]});
            n_e2[c] = $signed({i_q[2][c][COORD_WIDTH-1], i_q[2][c]})
                    - $signed({i_q[0][c][COORD_WIDTH-1], i_q[0][c]});
            for (int i = 0; i < 3; i++) begin
                n_d[i][c] = $signed({i_p[i][c][COORD_WIDTH-1], i_p[i][c]})
                          - $signed({i_q[0][c][COORD_WIDTH-1], i_q[0][c]});
            end
        end
        // cross product terms of e1 x e2
        n_m[0][0] = PW'(n_e1[1]) * PW'(n_e2[2]);
        n_m[0][1] = PW'(n_e1[2]) * PW'(n_e2[1]);
        n_m[1][0] = PW'(n_e1[2]) * PW'(n_e2[0]);
        n_m[1][1] = PW'(n_e1[0]) * PW'(n_e2[2]);
        n_m[2][0] = PW'(n_e1[0]) * PW'(n_e2[1]);
        n_m[2][1] = PW'(n_e1[1]) * PW'(n_e2[0]);
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_n[c] = NW'(r2_m[c][0]) - NW'(r2_m[c][1]);
        end
        n_degen = (n_n[0] == '0) && (n_n[1] == '0) && (n_n[2] == '0);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                n_t[i][c] = QW'(r3_n[c]) * QW'(r3_d[i][c]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i]   = SW'(r4_t[i][0]) + SW'(r4_t[i][1]) + SW'(r4_t[i][2]);
            n_neg[i] = n_s[i][SW-1];
            n_nz[i]  = (n_s[i] != '0);
        end
        // touching vertex never rejects
        n_res.degen    = r4_degen;
        n_res.one_side = (&n_nz) && ((&n_neg) || !(|n_neg));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r2_m <= n_m;
            r2_d <= n_d;
        end
        if (i_en[1]) begin
            r3_n     <= n_n;
            r3_d     <= r2_d;
            r3_degen <= n_degen;
        end
        if (i_en[2]) begin
            r4_t     <= n_t;
            r4_degen <= r3_degen;
        end
        if (i_en[3]) begin
            r5_res <= n_res;
        end
    end

    assign o_res = r5_res;

endmodule

### rtl/core/triangle_pair_plane_separation_unit.sv
// Triangle pair plane-separation screen.
// Input channel: i_valid / o_stall carry one word per pair: six packed
// vertices (x, y, z two's complement of COORD_WIDTH bits from bit 0 up)
// and a tag. Output channel: o_valid / i_stall carry may_intersect, the
// verdict code of the first failing check, and the tag.
// A word is taken whenever i_valid is high and o_stall low.
// Throughput: one pair per cycle unless o_stall is high; every stage is
// a fixed pipeline step. Pipeline: six register stages (unpack and
// shared-vertex compare, edge differences and cross terms, normal,
// distance products, sign sum, verdict and output register). The
// cross-term and distance multipliers set the stage depth.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall on the output holds the result; bubbles ahead of it close up,
// and o_stall rises only when all stages are full.
module triangle_pair_plane_separation_unit #(
    parameter int COORD_WIDTH = tpps_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [tpps_pkg::VERTEX_WIDTH-1:0]     i_vertex_a0,
    input  logic [tpps_pkg::VERTEX_WIDTH-1:0]     i_vertex_a1,
    input  logic [tpps_pkg::VERTEX_WIDTH-1:0]     i_vertex_a2,
    input  logic [tpps_pkg::VERTEX_WIDTH-1:0]     i_vertex_b0,
    input  logic [tpps_pkg::VERTEX_WIDTH-1:0]     i_vertex_b1,
    input  logic [tpps_pkg::VERTEX_WIDTH-1:0]     i_vertex_b2,
    input  logic [tpps_pkg::TAG_WIDTH-1:0]        i_pair_tag,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_may_intersect,
    output logic [tpps_pkg::VERDICT_WIDTH-1:0]    o_verdict,
    output logic [tpps_pkg::TAG_WIDTH-1:0]        o_tag_out
);
    localparam int NSTG  = 6;
    localparam int VW    = tpps_pkg::VERTEX_WIDTH;
    localparam int EXT_W = (3 * COORD_WIDTH > VW) ? 3 * COORD_WIDTH : VW;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_rdy;

    logic [2:0][2:0][COORD_WIDTH-1:0] r0_a;
    logic [2:0][2:0][COORD_WIDTH-1:0] r0_b;
    logic [4:0]                       r_shared;
    logic [tpps_pkg::TAG_WIDTH-1:0]   r_tag [NSTG];
    logic                             r_may;
    tpps_pkg::t_verdict               r_verdict;

    logic [VW-1:0]                    n_vin [6];
    logic [EXT_W-1:0]                 n_ext;
    logic [2:0][2:0][COORD_WIDTH-1:0] n_a;
    logic [2:0][2:0][COORD_WIDTH-1:0] n_b;
    logic                             n_shared;
    tpps_pkg::t_plane_res             n_ab;
    tpps_pkg::t_plane_res             n_ba;
    tpps_pkg::t_verdict               n_verdict;

    // ready chain, last stage first
    always_comb begin
        n_rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            n_rdy[k] = !r_vld[k] || n_rdy[k+1];
        end
    end

    assign o_stall = !n_rdy[0];

    // unpack; z bits above the field read as zero
    always_comb begin
        n_vin[0] = i_vertex_a0;
        n_vin[1] = i_vertex_a1;
        n_vin[2] = i_vertex_a2;
        n_vin[3] = i_vertex_b0;
        n_vin[4] = i_vertex_b1;
        n_vin[5] = i_vertex_b2;
        n_ext    = '0;
        for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++) begin
                n_ext     = EXT_W'(n_vin[v]);
                n_a[v][c] = n_ext[c*COORD_WIDTH +: COORD_WIDTH];
                n_ext     = EXT_W'(n_vin[v+3]);
                n_b[v][c] = n_ext[c*COORD_WIDTH +: COORD_WIDTH];
            end
        end
        n_shared = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (n_a[i] == n_b[j]) begin
                    n_shared = 1'b1;
                end
            end
        end
    end

    tpps_plane #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_plane_ab (
        .i_clk (i_clk),
        .i_en  (n_rdy[4:1]),
        .i_p   (r0_a),
        .i_q   (r0_b),
        .o_res (n_ab)
    );

    tpps_plane #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_plane_ba (
        .i_clk (i_clk),
        .i_en  (n_rdy[4:1]),
        .i_p   (r0_b),
        .i_q   (r0_a),
        .o_res (n_ba)
    );

    always_comb begin
        if (r_shared[4]) begin
            n_verdict = tpps_pkg::VERDICT_SHARED;
        end else if (n_ab.degen) begin
            n_verdict = tpps_pkg::VERDICT_B_DEGEN;
        end else if (n_ab.one_side) begin
            n_verdict = tpps_pkg::VERDICT_A_ONE_SIDE;
        end else if (n_ba.degen) begin
            n_verdict = tpps_pkg::VERDICT_A_DEGEN;
        end else if (n_ba.one_side) begin
            n_verdict = tpps_pkg::VERDICT_B_ONE_SIDE;
        end else begin
            n_verdict = tpps_pkg::VERDICT_STRADDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r0_a        <= n_a;
            r0_b        <= n_b;
            r_shared[0] <= n_shared;
            r_tag[0]    <= i_pair_tag;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (n_rdy[k]) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
        for (int k = 1; k < 5; k++) begin
            if (n_rdy[k]) begin
                r_shared[k] <= r_shared[k-1];
            end
        end
        if (n_rdy[NSTG-1]) begin
            r_verdict <= n_verdict;
            r_may     <= (n_verdict == tpps_pkg::VERDICT_STRADDLE);
        end
    end

    assign o_valid         = r_vld[NSTG-1];
    assign o_may_intersect = r_may;
    assign o_verdict       = r_verdict;
    assign o_tag_out       = r_tag[NSTG-1];

endmodule

### tb/triangle_pair_plane_separation_unit_tb.sv
`timescale 1ns / 100ps

module triangle_pair_plane_separation_unit_tb;

    localparam int CW         = tpps_pkg::COORD_WIDTH_DEF;
    localparam int CYCLE_CAP  = 500000;
    localparam int DRAIN_WAIT = 16;

    typedef logic [tpps_pkg::VERTEX_WIDTH-1:0] t_vtx;
    typedef logic signed [127:0]               t_wide;

    typedef struct {
        t_wide c[3];
    } t_point;

    typedef struct {
        t_vtx                           a[3];
        t_vtx                           b[3];
        logic [tpps_pkg::TAG_WIDTH-1:0] tag;
    } t_pair;

    typedef struct {
        logic                           may;
        tpps_pkg::t_verdict             verdict;
        logic [tpps_pkg::TAG_WIDTH-1:0] tag;
    } t_outcome;

    typedef enum int {
        PLANE_OK,
        PLANE_DEGEN,
        PLANE_ONE_SIDE
    } t_plane_outcome;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic [tpps_pkg::VERTEX_WIDTH-1:0]  i_vertex_a0;
    logic [tpps_pkg::VERTEX_WIDTH-1:0]  i_vertex_a1;
    logic [tpps_pkg::VERTEX_WIDTH-1:0]  i_vertex_a2;
    logic [tpps_pkg::VERTEX_WIDTH-1:0]  i_vertex_b0;
    logic [tpps_pkg::VERTEX_WIDTH-1:0]  i_vertex_b1;
    logic [tpps_pkg::VERTEX_WIDTH-1:0]  i_vertex_b2;
    logic [tpps_pkg::TAG_WIDTH-1:0]     i_pair_tag;
    logic                               o_valid;
    logic                               i_stall;
    logic                               o_may_intersect;
    logic [tpps_pkg::VERDICT_WIDTH-1:0] o_verdict;
    logic [tpps_pkg::TAG_WIDTH-1:0]     o_tag_out;

    t_outcome expected_verdicts[$];
    int       fail_count  = 0;
    int       cycle_count = 0;
    bit       calm        = 1'b0;

    triangle_pair_plane_separation_unit u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic t_point unpack_vtx(t_vtx v);
        t_point         p;
        logic [CW-1:0]  raw;
        int             idx;
        for (int k = 0; k < 3; k++) begin
            for (int n = 0; n < CW; n++) begin
                idx = k * CW + n;
                // z bits beyond the field read as zero for wide coordinates
                raw[n] = (idx < tpps_pkg::VERTEX_WIDTH) ? v[idx] : 1'b0;
            end
            p.c[k] = $signed(raw);
        end
        return p;
    endfunction

    function automatic bit same_point(t_point x, t_point y);
        return x.c[0] == y.c[0] && x.c[1] == y.c[1] && x.c[2] == y.c[2];
    endfunction

    function automatic int dist_sign(t_point nrm, t_point p, t_point q);
        t_wide s = 0;
        for (int k = 0; k < 3; k++)
            s += nrm.c[k] * (p.c[k] - q.c[k]);
        return (s > 0) ? 1 : ((s < 0) ? -1 : 0);
    endfunction

    // p0..p2 tested against the plane through q0..q2
    function automatic t_plane_outcome plane_test(t_point p0, t_point p1, t_point p2,
                                                  t_point q0, t_point q1, t_point q2);
        t_point e1, e2, nrm;
        int     s0, s1, s2;
        for (int k = 0; k < 3; k++) begin
            e1.c[k] = q1.c[k] - q0.c[k];
            e2.c[k] = q2.c[k] - q0.c[k];
        end
        nrm.c[0] = e1.c[1] * e2.c[2] - e1.c[2] * e2.c[1];
        nrm.c[1] = e1.c[2] * e2.c[0] - e1.c[0] * e2.c[2];
        nrm.c[2] = e1.c[0] * e2.c[1] - e1.c[1] * e2.c[0];
        if (nrm.c[0] == 0 && nrm.c[1] == 0 && nrm.c[2] == 0)
            return PLANE_DEGEN;
        s0 = dist_sign(nrm, p0, q0);
        s1 = dist_sign(nrm, p1, q0);
        s2 = dist_sign(nrm, p2, q0);
        // a zero distance is touching and never separates
        if (s0 * s1 > 0 && s0 * s2 > 0)
            return PLANE_ONE_SIDE;
        return PLANE_OK;
    endfunction

    function automatic t_outcome predict_verdict(t_pair w);
        t_point         pa[3];
        t_point         pb[3];
        t_outcome       r;
        t_plane_outcome po;
        for (int i = 0; i < 3; i++) begin
            pa[i] = unpack_vtx(w.a[i]);
            pb[i] = unpack_vtx(w.b[i]);
        end
        r.verdict = tpps_pkg::VERDICT_STRADDLE;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (same_point(pa[i], pb[j]))
                    r.verdict = tpps_pkg::VERDICT_SHARED;
        if (r.verdict == tpps_pkg::VERDICT_STRADDLE) begin
            po = plane_test(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]);
            if (po == PLANE_DEGEN)
                r.verdict = tpps_pkg::VERDICT_B_DEGEN;
            else if (po == PLANE_ONE_SIDE)
                r.verdict = tpps_pkg::VERDICT_A_ONE_SIDE;
        end
        if (r.verdict == tpps_pkg::VERDICT_STRADDLE) begin
            po = plane_test(pb[0], pb[1], pb[2], pa[0], pa[1], pa[2]);
            if (po == PLANE_DEGEN)
                r.verdict = tpps_pkg::VERDICT_A_DEGEN;
            else if (po == PLANE_ONE_SIDE)
                r.verdict = tpps_pkg::VERDICT_B_ONE_SIDE;
        end
        r.may = (r.verdict == tpps_pkg::VERDICT_STRADDLE);
        r.tag = w.tag;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_vtx vtx(int x, int y, int z);
        t_vtx        v = '0;
        logic [31:0] cv;
        int          idx;
        for (int k = 0; k < 3; k++) begin
            cv = (k == 0) ? x : ((k == 1) ? y : z);
            for (int n = 0; n < CW; n++) begin
                idx = k * CW + n;
                if (idx < tpps_pkg::VERTEX_WIDTH)
                    v[idx] = cv[n];
            end
        end
        return v;
    endfunction

    function automatic int rand_coord(int lim);
        return int'($urandom_range(2 * lim - 1, 0)) - lim;
    endfunction

    function automatic t_vtx rand_vtx(int lim);
        return vtx(rand_coord(lim), rand_coord(lim), rand_coord(lim));
    endfunction

    function automatic t_vtx raw_vtx();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[tpps_pkg::VERTEX_WIDTH-1:0];
    endfunction

    function automatic t_vtx line_vtx(int ox, int oy, int oz, int dx, int dy, int dz, int m);
        return vtx(ox + m * dx, oy + m * dy, oz + m * dz);
    endfunction

    // mostly short idle runs, now and then a long one
    function automatic int pick_len();
        if ($urandom_range(15, 0) == 0)
            return int'($urandom_range(40, 10));
        return int'($urandom_range(3, 1));
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    task automatic push_pair(t_pair w);
        int gap;
        gap = (!calm && $urandom_range(2, 0) == 0) ? pick_len() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_vertex_a0 = w.a[0];
        i_vertex_a1 = w.a[1];
        i_vertex_a2 = w.a[2];
        i_vertex_b0 = w.b[0];
        i_vertex_b1 = w.b[1];
        i_vertex_b2 = w.b[2];
        i_pair_tag  = w.tag;
        i_valid     = 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_verdicts.insert(expected_verdicts.size(), predict_verdict(w));
    endtask

    task automatic send_tri(t_vtx a0, t_vtx a1, t_vtx a2, t_vtx b0, t_vtx b1, t_vtx b2,
                            logic [tpps_pkg::TAG_WIDTH-1:0] tag);
        t_pair w;
        w.a[0] = a0;
        w.a[1] = a1;
        w.a[2] = a2;
        w.b[0] = b0;
        w.b[1] = b1;
        w.b[2] = b2;
        w.tag  = tag;
        push_pair(w);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_pair();
        t_pair w;
        int    kind, lim, zp, m, ox, oy, oz, dx, dy, dz;
        kind = int'($urandom_range(9, 0));
        lim  = (kind == 2) ? 4 : ((kind == 9) ? 32768 : 2000);
        for (int i = 0; i < 3; i++) begin
            w.a[i] = (kind <= 1) ? raw_vtx() : rand_vtx(lim);
            w.b[i] = (kind <= 1) ? raw_vtx() : rand_vtx(lim);
        end
        w.tag = $urandom;
        ox = rand_coord(1000);
        oy = rand_coord(1000);
        oz = rand_coord(1000);
        dx = rand_coord(8);
        dy = rand_coord(8);
        dz = rand_coord(8);
        m  = rand_coord(4);
        zp = rand_coord(100);
        case (kind)
            3: w.b[$urandom_range(2, 0)] = w.a[$urandom_range(2, 0)];
            4: begin
                w.b[0] = line_vtx(ox, oy, oz, dx, dy, dz, 0);
                w.b[1] = line_vtx(ox, oy, oz, dx, dy, dz, 1);
                w.b[2] = line_vtx(ox, oy, oz, dx, dy, dz, m);
            end
            5: begin
                w.a[0] = line_vtx(ox, oy, oz, dx, dy, dz, 0);
                w.a[1] = line_vtx(ox, oy, oz, dx, dy, dz, m);
                w.a[2] = line_vtx(ox, oy, oz, dx, dy, dz, 1);
            end
            6, 7: begin
                // B flat in z; kind 7 puts A there too, kind 6 only one A corner
                for (int i = 0; i < 3; i++)
                    w.b[i] = vtx(rand_coord(1000), rand_coord(1000), zp);
                w.a[0] = vtx(rand_coord(1000), rand_coord(1000), zp);
                if (kind == 7) begin
                    w.a[1] = vtx(rand_coord(1000), rand_coord(1000), zp);
                    w.a[2] = vtx(rand_coord(1000), rand_coord(1000), zp);
                end
            end
            default: ;
        endcase
        push_pair(w);
    endtask

    // ---------------- tests ----------------

    task automatic test_straddle_and_touch();
        send_tri(vtx(3, -5, -5), vtx(3, 20, -5), vtx(3, -5, 20),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
        send_tri(vtx(1, 1, 0), vtx(2, 1, 5), vtx(1, 2, 5),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
        send_tri(vtx(20, 20, 0), vtx(30, 20, 0), vtx(20, 30, 0),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
    endtask

    task automatic test_shared_vertex();
        send_tri(vtx(0, 0, 0), vtx(5, 5, 5), vtx(7, 1, 3),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
        send_tri(vtx(4, 4, 4), vtx(9, 2, 1), vtx(10, 0, 0),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
        // one coordinate off on every corner
        send_tri(vtx(0, 0, 1), vtx(10, 1, 0), vtx(1, 10, 0),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
    endtask

    task automatic test_degenerate_planes();
        send_tri(vtx(3, -5, -5), vtx(3, 20, -5), vtx(3, -5, 20),
                 vtx(0, 0, 0), vtx(1, 1, 1), vtx(2, 2, 2), $urandom);
        send_tri(vtx(3, -5, -5), vtx(3, 20, -5), vtx(3, -5, 20),
                 vtx(5, 5, 5), vtx(5, 5, 5), vtx(5, 5, 5), $urandom);
        send_tri(vtx(1, 1, -1), vtx(1, 1, 1), vtx(1, 1, 3),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
    endtask

    task automatic test_one_side();
        send_tri(vtx(1, 1, 1), vtx(2, 1, 1), vtx(1, 2, 3),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
        send_tri(vtx(1, 1, -1), vtx(2, 1, -4), vtx(1, 2, -3),
                 vtx(0, 0, 0), vtx(10, 0, 0), vtx(0, 10, 0), $urandom);
        send_tri(vtx(3, -5, -5), vtx(3, 20, -5), vtx(3, -5, 20),
                 vtx(0, 0, 0), vtx(1, 0, 0), vtx(0, 10, 0), $urandom);
    endtask

    task automatic test_coordinate_extremes();
        send_tri('0, '0, '0, '0, '0, '0, '0);
        send_tri('0, '0, '0, '1, '1, '1, '1);
        send_tri(vtx(32767, 32767, -32768), vtx(32767, -32768, -32768),
                 vtx(-32768, 32767, -32768), vtx(-32768, -32768, -32768),
                 vtx(32767, -32768, 32767), vtx(-32768, 32767, 32767), $urandom);
        send_tri(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h5555_AAAA_5555,
                 48'hAAAA_5555_AAAA, 48'h0001_FFFF_0001, 48'hFFFF_0001_FFFF, $urandom);
    endtask

    task automatic test_back_to_back();
        calm = 1'b1;
        repeat (150) random_pair();
        calm = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (950) begin
            random_pair();
            // occasionally let the pipe run dry before carrying on
            if ($urandom_range(119, 0) == 0)
                drain_results();
        end
    endtask

    // ---------------- receiver ----------------

    initial begin
        int left;
        left    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left > 0) begin
                i_stall = 1'b1;
                left--;
            end else begin
                i_stall = 1'b0;
                if (!calm && $urandom_range(3, 0) == 0)
                    left = pick_len();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_verdicts.size() == 0) begin
                note_failure($sformatf("unexpected word, tag %h verdict %0d",
                                       o_tag_out, o_verdict));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_may_intersect !== want.may || o_verdict !== want.verdict ||
                    o_tag_out !== want.tag)
                    note_failure($sformatf(
                        "expected may=%0b verdict=%0d tag=%h, got may=%0b verdict=%0d tag=%h",
                        want.may, want.verdict, want.tag,
                        o_may_intersect, o_verdict, o_tag_out));
            end
        end
    end

    // ---------------- sequence ----------------

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_vertex_a0 = '0;
        i_vertex_a1 = '0;
        i_vertex_a2 = '0;
        i_vertex_b0 = '0;
        i_vertex_b1 = '0;
        i_vertex_b2 = '0;
        i_pair_tag  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_straddle_and_touch();
        test_shared_vertex();
        test_degenerate_planes();
        test_one_side();
        test_coordinate_extremes();
        drain_results();
        test_back_to_back();
        test_random_mix();

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
